// ----- rtl/ictf_pkg.sv -----
`default_nettype none
package ictf_pkg;

  localparam int unsigned TableLen    = 24;
  localparam int unsigned DefSteps    = 16;
  localparam logic [15:0] AlphaReset  = 16'd64225;
  localparam logic [15:0] PeriodReset = 16'd655;
  localparam logic signed [33:0] PiQ30 = 34'sd3373259426;

  // Register indexes on the configuration port.
  localparam logic RegAlpha  = 1'b0;
  localparam logic RegPeriod = 1'b1;

  // Item kinds.
  localparam logic KindSample = 1'b0;
  localparam logic KindTick   = 1'b1;

  // Truncated arctangent table, Q30 radians.
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0:  r = 34'sh3243F6A8;
      5'd1:  r = 34'sh1DAC6705;
      5'd2:  r = 34'sh0FADBAFC;
      5'd3:  r = 34'sh07F56EA6;
      5'd4:  r = 34'sh03FEAB76;
      5'd5:  r = 34'sh01FFD55B;
      5'd6:  r = 34'sh00FFFAAA;
      5'd7:  r = 34'sh007FFF55;
      5'd8:  r = 34'sh003FFFEA;
      5'd9:  r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF;
      5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;
      5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;
      5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;
      5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;
      5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF;
      5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF;
      5'd23: r = 34'sh0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ictf_cordic.sv -----
`default_nettype none
// Vectoring CORDIC: one micro-rotation per cycle, result rounded to 2^-13 rad.
module ictf_cordic #(
  parameter int unsigned STEPS = ictf_pkg::DefSteps
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] y_in,
  input  wire logic signed [15:0] x_in,
  output logic                    done,
  output logic signed [15:0]      angle
);
  import ictf_pkg::*;

  localparam int unsigned NSteps = (STEPS > TableLen) ? TableLen : STEPS;

  logic signed [33:0] x, y, z;
  logic [4:0]         step;
  logic               busy;
  logic signed [33:0] xs, ys, zr;

  assign xs = x >>> step;
  assign ys = y >>> step;
  // Add half and floor to 2^-13; the result fits 16 bits.
  assign zr = (z + 34'sd65536) >>> 17;
  // The angle follows the accumulator, so it is valid while done is high.
  assign angle = zr[15:0];

  // Set up the quadrant, or finish with a zero angle for a zero vector; then rotate until the step count runs out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else if (start) begin
      step <= '0;
      if (x_in == 16'sd0 && y_in == 16'sd0) begin
        busy <= 1'b0;
        done <= 1'b1;
        z    <= '0;
      end else begin
        busy <= 1'b1;
        done <= 1'b0;
        if (x_in < 0) begin
          z <= (y_in >= 0) ? PiQ30 : -PiQ30;
          x <= -(34'(x_in) <<< 14);
          y <= -(34'(y_in) <<< 14);
        end else begin
          z <= '0;
          x <= 34'(x_in) <<< 14;
          y <= 34'(y_in) <<< 14;
        end
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_q30(step);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_q30(step);
      end
      if (step == 5'(NSteps - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
      step <= step + 5'd1;
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ictf_serial_mac.sv -----
`default_nettype none
// Shift-and-add multiplier: one bit of the unsigned multiplier per cycle.
module ictf_serial_mac (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [47:0] mcand,
  input  wire logic [16:0]        mplier,
  output logic                    done,
  output logic signed [64:0]      product
);
  logic signed [64:0] acc;
  logic signed [64:0] sh;
  logic [16:0]        bits;
  logic [4:0]         cnt;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      acc  <= '0;
      sh   <= 65'(mcand);
      bits <= mplier;
      cnt  <= '0;
    end else if (busy) begin
      if (bits[0]) acc <= acc + sh;
      sh   <= sh <<< 1;
      bits <= bits >> 1;
      cnt  <= cnt + 5'd1;
      if (cnt == 5'd16) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign product = acc;

endmodule
`default_nettype wire

// ----- rtl/imu_complementary_tilt_filter_top.sv -----
`default_nettype none
// Channel   | Direction | Handshake          | Payload
// in        | input     | in_valid/in_stall  | kind, accel_x/y/z, gyro_x/y
// out       | output    | out_valid/out_stall| roll, pitch
// cfg       | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// A sample item is worked as roll then pitch, each a
// CORDIC pass followed by two serial multiplies and their hand-offs.
// A tick item loads the angles into the output register if a sample has updated them since the last result.
// Input is stalled while a sample is in work or a result waits.
// rst is synchronous; it restores register defaults and zero angles.
module imu_complementary_tilt_filter_top #(
  parameter int unsigned CORDIC_STEPS = ictf_pkg::DefSteps
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               kind,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] gyro_x,
  input  wire logic signed [15:0] gyro_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      roll,
  output logic signed [15:0]      pitch,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import ictf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CORD  = 7'b0000010,
    S_MUL_A = 7'b0000100,
    S_MUL_B = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_NEXT  = 7'b1000000
  } state_t;

  state_t state;
  logic [15:0] alpha, period;
  logic signed [15:0] roll_angle, pitch_angle;
  logic fresh_flag;
  logic axis;                  // 0 roll, 1 pitch
  logic signed [15:0] ax, ay, az, gx, gy;
  logic signed [15:0] acc_ang;
  logic signed [64:0] part_a;

  logic in_acc;
  logic cord_start, cord_done;
  logic signed [15:0] cord_y, cord_ang;
  logic mul_start, mul_done;
  logic signed [47:0] mul_cand;
  logic [16:0] mul_plier;
  logic signed [64:0] mul_prod;
  logic signed [64:0] total, rounded;
  logic signed [15:0] nax, cur_angle, cur_rate, sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign in_acc    = in_valid && !in_stall;

  assign nax       = (ax == -16'sd32768) ? 16'sd32767 : -ax;
  assign cord_y    = axis ? nax : ay;
  assign cur_angle = axis ? pitch_angle : roll_angle;
  assign cur_rate  = axis ? gy : gx;

  // The first multiply forms alpha*(angle*2^14 + rate*dt); the second
  // (1-alpha)*acc*2^14. The multiplier takes its operands in the cycle
  // after the start request.
  always_comb begin
    if (state == S_MUL_A) begin
      mul_cand  = (48'(cur_angle) <<< 14) + 48'(cur_rate) * $signed({1'b0, period});
      mul_plier = {1'b0, alpha};
    end else begin
      mul_cand  = 48'(acc_ang) <<< 14;
      mul_plier = 17'h10000 - {1'b0, alpha};
    end
  end

  assign total   = part_a + mul_prod;
  assign rounded = (total + (65'sd1 <<< 29)) >>> 30;
  assign sat     = (rounded > 65'sd32767) ? 16'sh7FFF :
                   (rounded < -65'sd32768) ? 16'sh8000 : rounded[15:0];

  ictf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .start(cord_start), .y_in(cord_y), .x_in(az),
    .done(cord_done), .angle(cord_ang)
  );

  ictf_serial_mac u_mac (
    .clk, .rst, .start(mul_start), .mcand(mul_cand), .mplier(mul_plier),
    .done(mul_done), .product(mul_prod)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha  <= AlphaReset;
      period <= PeriodReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegAlpha) alpha <= cfg_data;
      else period <= cfg_data;
    end
  end

  // Sequencer over both axes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      roll_angle  <= '0;
      pitch_angle <= '0;
      fresh_flag  <= 1'b0;
      out_valid   <= 1'b0;
      axis        <= 1'b0;
      cord_start  <= 1'b0;
      mul_start   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          mul_start  <= 1'b0;
          cord_start <= in_acc && (kind == KindSample);
          if (in_acc) begin
            if (kind == KindSample) begin
              ax <= accel_x; ay <= accel_y; az <= accel_z;
              gx <= gyro_x;  gy <= gyro_y;
              axis <= 1'b0;
              state <= S_CORD;
            end else if (fresh_flag) begin
              roll  <= roll_angle;
              pitch <= pitch_angle;
              out_valid <= 1'b1;
              fresh_flag <= 1'b0;
            end
          end
        end
        S_CORD: begin
          cord_start <= 1'b0;
          mul_start  <= cord_done;
          if (cord_done) begin
            acc_ang   <= cord_ang;
            state     <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          cord_start <= 1'b0;
          mul_start  <= 1'b0;
          if (mul_done) begin
            part_a <= mul_prod;
            state  <= S_MUL_B;
          end
        end
        S_MUL_B: begin
          cord_start <= 1'b0;
          mul_start  <= 1'b1;
          state      <= S_WAIT;
        end
        S_WAIT: begin
          cord_start <= 1'b0;
          mul_start  <= 1'b0;
          if (mul_done) state <= S_SUM;
        end
        S_SUM: begin
          cord_start <= 1'b0;
          mul_start  <= 1'b0;
          if (axis) begin
            pitch_angle <= sat;
            fresh_flag  <= 1'b1;
            state       <= S_IDLE;
          end else begin
            roll_angle <= sat;
            state      <= S_NEXT;
          end
        end
        S_NEXT: begin
          axis       <= 1'b1;
          cord_start <= 1'b1;
          mul_start  <= 1'b0;
          state      <= S_CORD;
        end
        default: begin
          cord_start <= 1'b0;
          mul_start  <= 1'b0;
          state      <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- dv/tb_imu_complementary_tilt_filter_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_imu_complementary_tilt_filter_top;
  import ictf_pkg::*;

  localparam int unsigned Steps = DefSteps;
  localparam int unsigned SampleCycles = 2 * Steps + 86;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
  } imu_item_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } tilt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KindSample;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0, gyro_x = '0, gyro_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] roll, pitch;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = RegAlpha;
  logic [15:0] cfg_data = '0;

  imu_complementary_tilt_filter_top #(.CORDIC_STEPS(Steps)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .gyro_x(gyro_x), .gyro_y(gyro_y),
    .out_valid(out_valid), .out_stall(out_stall), .roll(roll), .pitch(pitch),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state and register copies.
  logic [15:0] alpha_q = AlphaReset;
  logic [15:0] period_q = PeriodReset;
  logic signed [15:0] roll_q = '0, pitch_q = '0;
  logic fresh_q = 1'b0;

  imu_item_t pending_items[$];
  tilt_t expected_tilts[$];
  int errors = 0;
  int samples_sent = 0, ticks_sent = 0, tilts_seen = 0;
  bit quiet = 1'b0;
  bit drv_done = 1'b0;
  int idle_in = 0, idle_out = 0;
  int stall_cycles = 0;

  function automatic longint floor_sh(longint x, int n);
    return x >>> n;
  endfunction

  // Vectoring CORDIC atan2, result in 2^-13 radians.
  function automatic longint tilt_atan2(longint y, longint x);
    longint z, xs, ys;
    int n;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PiQ30) : -longint'(PiQ30);
      x = -x;
      y = -y;
    end
    x = x * 16384;
    y = y * 16384;
    n = (Steps > TableLen) ? TableLen : Steps;
    for (int i = 0; i < n; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(atan_q30(5'(i)));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_q30(5'(i)));
      end
    end
    return floor_sh(z + 65536, 17);
  endfunction

  function automatic logic signed [15:0] fuse_angle(logic signed [15:0] ang,
      longint rate, longint acc);
    longint a, inner, total, r;
    a = longint'(alpha_q);
    inner = longint'(ang) * 16384 + rate * longint'(period_q);
    total = a * inner + (65536 - a) * (acc * 16384);
    r = floor_sh(total + (longint'(1) << 29), 30);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // Updates the predicted angles for one accepted sample, or queues the expected result for a tick after fresh angles.
  task automatic predict_tilt(imu_item_t it);
    longint nax;
    tilt_t t;
    if (it.kind == KindSample) begin
      nax = (it.ax == -16'sd32768) ? 32767 : -longint'(it.ax);
      roll_q = fuse_angle(roll_q, it.gx, tilt_atan2(it.ay, it.az));
      pitch_q = fuse_angle(pitch_q, it.gy, tilt_atan2(nax, it.az));
      fresh_q = 1'b1;
    end else if (fresh_q) begin
      t.roll = roll_q;
      t.pitch = pitch_q;
      expected_tilts.push_back(t);
      fresh_q = 1'b0;
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // Input driver.
  always @(posedge clk) begin
    imu_item_t it;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_tilt({kind, accel_x, accel_y, accel_z, gyro_x, gyro_y});
        if (kind == KindSample) samples_sent++; else ticks_sent++;
      end
      if (in_valid && in_stall) begin
        // Hold the stalled item.
      end else if (idle_in > 0) begin
        idle_in--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        idle_in = $urandom_range(1, 4) - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        {kind, accel_x, accel_y, accel_z, gyro_x, gyro_y} <= it;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and random back-pressure.
  always @(posedge clk) begin
    tilt_t exp_t;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        tilts_seen++;
        if (expected_tilts.size() == 0) begin
          $error("unexpected result roll=%0d pitch=%0d", roll, pitch);
          errors++;
        end else begin
          exp_t = expected_tilts.pop_front();
          if (roll !== exp_t.roll) begin
            $error("roll: expected %0d actual %0d", exp_t.roll, roll);
            errors++;
          end
          if (pitch !== exp_t.pitch) begin
            $error("pitch: expected %0d actual %0d", exp_t.pitch, pitch);
            errors++;
          end
        end
      end
      if (idle_out > 0) begin
        idle_out--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        idle_out = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no accepted item, result or configuration write.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (!drv_done) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic imu_item_t rand_sample(bit wild);
    imu_item_t it;
    it.kind = KindSample;
    it.ax = $urandom;
    it.ay = $urandom;
    it.az = $urandom;
    it.gx = $urandom;
    it.gy = $urandom;
    if (!wild) begin
      // Plausible accelerations near 1 g and modest rates.
      it.ax = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      it.ay = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      it.az = $signed(16'($urandom_range(0, 24000))) - 16'sd8000;
      it.gx = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
      it.gy = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
    end
    return it;
  endfunction

  function automatic imu_item_t make_item(logic k, int ax, int ay, int az, int gx, int gy);
    imu_item_t it;
    it = {k, 16'(ax), 16'(ay), 16'(az), 16'(gx), 16'(gy)};
    return it;
  endfunction

  // Waits until the block has drained every queued item and result.
  task automatic drain_block();
    while (pending_items.size() > 0 || in_valid || expected_tilts.size() > 0)
      @(posedge clk);
    repeat (SampleCycles + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == RegAlpha) alpha_q = val; else period_q = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    imu_item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3) it = make_item(KindTick, $urandom, $urandom, $urandom, $urandom, $urandom);
      else it = rand_sample(r == 9);
      pending_items.push_back(it);
    end
  endtask

  // Stimulus sequence.
  initial begin
    logic [15:0] alphas[4];
    logic [15:0] periods[4];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Tick with nothing fresh, then the field extremes and special cases.
    pending_items.push_back(make_item(KindTick, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(KindSample, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(KindTick, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(KindTick, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(KindSample, -32768, 0, 100, 32767, -32768));
    pending_items.push_back(make_item(KindTick, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(KindSample, 32767, 0, -5000, -32768, 32767));
    pending_items.push_back(make_item(KindSample, 0, 0, -32768, 0, 0));
    pending_items.push_back(make_item(KindTick, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(KindSample, 1, -32768, -32768, 32767, 32767));
    pending_items.push_back(make_item(KindSample, -32768, 32767, 32767, -1, 1));
    pending_items.push_back(make_item(KindTick, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(KindSample, 0, 32767, 0, 0, 0));
    pending_items.push_back(make_item(KindSample, 0, -32768, 0, 0, 0));
    pending_items.push_back(make_item(KindTick, 0, 0, 0, 0, 0));
    for (int i = 0; i < 6; i++)
      pending_items.push_back(make_item(KindSample, 0, 0, 0, 32767, 32767));
    pending_items.push_back(make_item(KindTick, 0, 0, 0, 0, 0));
    drain_block();

    // Register settings, extremes included; the sender waits out each one.
    alphas = '{16'd0, 16'd65535, 16'd32768, 16'($urandom)};
    periods = '{16'd65535, 16'd0, 16'd655, 16'($urandom)};
    for (int p = 0; p < 4; p++) begin
      write_reg(RegAlpha, alphas[p]);
      write_reg(RegPeriod, periods[p]);
      random_phase(350);
      drain_block();
    end
    write_reg(RegAlpha, AlphaReset);
    write_reg(RegPeriod, PeriodReset);
    random_phase(230);
    while (pending_items.size() > 100) @(posedge clk);
    quiet = 1'b1;
    drain_block();

    drv_done = 1'b1;
    $display("Covered %0d samples and %0d ticks, %0d tilt results checked,",
             samples_sent, ticks_sent, tilts_seen);
    $display("over five blend and period settings with random stalls.");
    if (errors == 0 && expected_tilts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/ictf_pkg.sv
rtl/ictf_cordic.sv
rtl/ictf_serial_mac.sv
rtl/imu_complementary_tilt_filter_top.sv
dv/tb_imu_complementary_tilt_filter_top.sv
